FILE: sv/spd_pkg.sv
// Shared constants, register indexes and control/status types of the shortest-path block.
package spd_pkg;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_WEIGHT_BITS  = 16;

  localparam int IN_WEIGHT_W = 16;
  localparam int VERTEX_W    = 4;
  localparam int DISTANCE_W  = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int COUNT_W     = 5;
  localparam int OUT_DATA_W  = VERTEX_W + DISTANCE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic accept;       // take matrix words
    logic recalc;       // one step of the row/column rebuild
    logic init;         // reset the search arrays; only the source is known
    logic scan;         // one step of the minimum search
    logic settle;       // settle the chosen vertex
    logic relax_issue;  // issue one matrix read of the relaxation sweep
    logic emit;         // load one path word into the output register
    logic emit_unr;     // load the unreachable word
  } spd_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic cnt_wr;
    logic start;
    logic recal_done;
    logic cfg_bad;
    logic idx_last;
    logic found;
    logic u_is_dst;
    logic walk_last;
    logic out_free;
  } spd_sts_t;

endpackage

FILE: sv/spd_ctrl.sv
// Sequencer of the shortest-path block: load, search sweeps and path output.
module spd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  spd_pkg::spd_sts_t sts,
  output spd_pkg::spd_cmd_t cmd
);
  import spd_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_RECALC, S_INIT, S_SCAN, S_PICK, S_RELAX, S_DRAIN, S_EMIT, S_UNREACH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        cmd.accept = 1'b1;
        if (sts.cnt_wr) state_nxt = S_RECALC;
        else if (sts.start) state_nxt = S_INIT;
      end
      S_RECALC: begin
        cmd.recalc = 1'b1;
        if (sts.recal_done) state_nxt = S_LOAD;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = sts.cfg_bad ? S_UNREACH : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.idx_last) state_nxt = S_PICK;
      end
      S_PICK: begin
        if (!sts.found) begin
          state_nxt = S_UNREACH;
        end else begin
          cmd.settle = 1'b1;
          state_nxt  = sts.u_is_dst ? S_EMIT : S_RELAX;
        end
      end
      S_RELAX: begin
        cmd.relax_issue = 1'b1;
        if (sts.idx_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_SCAN;
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.walk_last) state_nxt = S_LOAD;
        end
      end
      S_UNREACH: begin
        if (sts.out_free) begin
          cmd.emit_unr = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else state_r <= state_nxt;
  end

  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && !sts.cnt_wr && sts.start) |=> state_r == S_INIT)
    else $error("search did not start after last entry");
  a_settle_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.settle |-> sts.found)
    else $error("settle without a candidate");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.emit_unr) |-> sts.out_free)
    else $error("output register overwritten");
endmodule

FILE: sv/spd_dpath.sv
// Datapath of the shortest-path block: matrix memory, search arrays and output register.
module spd_dpath #(
  parameter int MAX_VERTICES = spd_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = spd_pkg::DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spd_pkg::spd_cmd_t             cmd,
  output spd_pkg::spd_sts_t             sts,
  input  logic                          in_valid,
  input  logic [spd_pkg::IN_WEIGHT_W-1:0] in_weight,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spd_pkg::VERTEX_W-1:0]  out_vertex,
  output logic [spd_pkg::DISTANCE_W-1:0] out_distance,
  output logic                          out_reach,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spd_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int PW = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
  localparam int DW = WEIGHT_BITS + VW;
  localparam int AW = 2 * VW;

  logic [COUNT_W-1:0]  cnt_r;
  logic [VERTEX_W-1:0] src_r, dst_r;
  logic [31:0]         n_lim;
  logic [NW-1:0]       n_act, n_m1;
  logic [VW-1:0]       src_v, dst_v;

  logic [PW-1:0] pos_r, row_r, col_r;
  logic          row_ok, in_fire;
  logic [WEIGHT_BITS-1:0] w_in, rd_q;
  logic [WEIGHT_BITS-1:0] mem [2**AW];

  logic [DW-1:0] dist_r [MAX_VERTICES];
  logic [VW-1:0] pred_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] known_r, settled_r;
  logic [VW-1:0] idx_r, u_r, v_r, k_r, rj_r;
  logic [DW-1:0] best_r, cand;
  logic          found_r, rv_r, scan_hit, relax_hit, walk_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= COUNT_RESET;
      src_r <= '0;
      dst_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COUNT:  cnt_r <= cfg_data;
        CFG_SOURCE: src_r <= cfg_data[VERTEX_W-1:0];
        CFG_TARGET: dst_r <= cfg_data[VERTEX_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the vertex count into 1..MAX_VERTICES.
  always_comb begin
    if (cnt_r == '0) n_lim = 32'd1;
    else if (32'(cnt_r) > 32'(MAX_VERTICES)) n_lim = 32'(MAX_VERTICES);
    else n_lim = 32'(cnt_r);
  end
  assign n_act = NW'(n_lim);
  assign n_m1  = n_act - NW'(1);
  assign src_v = VW'(src_r);
  assign dst_v = VW'(dst_r);

  assign in_fire = in_valid && cmd.accept;
  assign row_ok  = row_r < PW'(n_act);
  assign w_in    = WEIGHT_BITS'(in_weight);

  // Load position kept as row and column; a new count rebuilds them by subtraction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_valid && cfg_index == CFG_COUNT) begin
      row_r <= '0;
      col_r <= pos_r;
    end else if (cmd.recalc && !sts.recal_done) begin
      col_r <= col_r - PW'(n_act);
      row_r <= row_r + PW'(1);
    end else if (in_fire) begin
      if (in_last) begin
        pos_r <= '0;
        row_r <= '0;
        col_r <= '0;
      end else if (row_ok) begin
        pos_r <= pos_r + PW'(1);
        if (col_r == PW'(n_m1)) begin
          col_r <= '0;
          row_r <= row_r + PW'(1);
        end else begin
          col_r <= col_r + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && row_ok) mem[{row_r[VW-1:0], col_r[VW-1:0]}] <= w_in;
    rd_q <= mem[{u_r, idx_r}];
  end

  assign scan_hit  = !settled_r[idx_r] && known_r[idx_r] &&
                     (!found_r || dist_r[idx_r] < best_r);
  assign cand      = best_r + DW'(rd_q);
  assign relax_hit = rv_r && (rj_r != u_r) && (rd_q != '0) && !settled_r[rj_r] &&
                     (!known_r[rj_r] || cand < dist_r[rj_r]);
  assign walk_last = (v_r == src_v) || (NW'(k_r) == n_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r   <= '0;
      settled_r <= '0;
      found_r   <= 1'b0;
      rv_r      <= 1'b0;
      idx_r     <= '0;
    end else begin
      rv_r <= cmd.relax_issue;
      if (cmd.init) begin
        known_r   <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << src_v;
        settled_r <= '0;
        found_r   <= 1'b0;
        idx_r     <= '0;
      end else if (cmd.scan || cmd.relax_issue) begin
        idx_r <= sts.idx_last ? '0 : idx_r + VW'(1);
      end
      if (cmd.scan && scan_hit) found_r <= 1'b1;
      if (cmd.settle) begin
        settled_r[u_r] <= 1'b1;
        found_r        <= 1'b0;
      end
      if (relax_hit) known_r[rj_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rj_r <= idx_r;
    if (cmd.init) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        dist_r[i] <= '0;
        pred_r[i] <= src_v;
      end
    end
    if (cmd.scan && scan_hit) begin
      u_r    <= idx_r;
      best_r <= dist_r[idx_r];
    end
    if (relax_hit) begin
      dist_r[rj_r] <= cand;
      pred_r[rj_r] <= u_r;
    end
    if (cmd.settle) begin
      v_r <= dst_v;
      k_r <= '0;
    end else if (cmd.emit) begin
      v_r <= pred_r[v_r];
      k_r <= k_r + VW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.emit || cmd.emit_unr) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_vertex   <= VERTEX_W'(v_r);
      out_distance <= DISTANCE_W'(best_r);
      out_reach    <= 1'b1;
      out_last     <= walk_last;
    end else if (cmd.emit_unr) begin
      out_vertex   <= dst_r;
      out_distance <= '0;
      out_reach    <= 1'b0;
      out_last     <= 1'b1;
    end
  end

  always_comb begin
    sts            = '0;
    sts.cnt_wr     = cfg_valid && (cfg_index == CFG_COUNT);
    sts.start      = in_fire && in_last;
    sts.recal_done = col_r < PW'(n_act);
    sts.cfg_bad    = (32'(src_r) >= n_lim) || (32'(dst_r) >= n_lim);
    sts.idx_last   = NW'(idx_r) == n_m1;
    sts.found      = found_r;
    sts.u_is_dst   = u_r == dst_v;
    sts.walk_last  = walk_last;
    sts.out_free   = !out_valid || out_ready;
  end

  a_settle_mark: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.settle |=> settled_r[$past(u_r)])
    else $error("settled vertex not marked");
  a_relax_unsettled: assert property (@(posedge clk) disable iff (!rst_n)
    relax_hit |-> (rj_r != u_r))
    else $error("relaxation touched the settling vertex");
  a_first_known: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.init && !sts.cfg_bad) |=> known_r[$past(src_v)])
    else $error("source not marked known");
endmodule

FILE: sv/shortest_path_dijkstra_matrix.sv
// Top level of the adjacency-matrix shortest-path search block.
// Usage:
//   Input channel (in_*): one matrix word per beat, row-major over the
//   configured vertex count; a zero off the diagonal means no edge. in_tlast
//   marks the final word, which is stored and then starts the search.
//   Surplus words beyond n*n are dropped until in_tlast restarts loading.
//   Result channel (out_*): the path from target back to source, one vertex
//   per word, each with the total distance; out_tlast on the source word. An
//   unreachable target gives a single word with out_tuser low.
//   Config channel (cfg_*): vertex count, source and target by index; always
//   ready. A new vertex count holds in_tready low while the load position
//   is rebuilt.
// Timing: one matrix word per cycle while loading. The search uses a
//   matrix memory with one read port and a sequential minimum scan: for each
//   settled vertex a scan over all vertices, a pick step and a relaxation
//   sweep over one matrix row, then the path is emitted word by word.
// Reset clears the configuration to 16 vertices, source 0, target 0, and
//   empties the output register. A stalled receiver holds the path walk; the
//   output register keeps its word until taken.
module shortest_path_dijkstra_matrix #(
  parameter int MAX_VERTICES = spd_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = spd_pkg::DEF_WEIGHT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [spd_pkg::IN_WEIGHT_W-1:0] in_tdata,   // [15:0] weight
  input  logic                            in_tlast,   // last_entry
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spd_pkg::OUT_DATA_W-1:0]  out_tdata,  // [3:0] vertex, [23:4] distance
  output logic                            out_tuser,  // [0] reachable
  output logic                            out_tlast,  // last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import spd_pkg::*;

  spd_cmd_t cmd;
  spd_sts_t sts;
  logic [VERTEX_W-1:0]   vertex;
  logic [DISTANCE_W-1:0] distance;

  // Sequencer: owns the phase of the run.
  spd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath: matrix memory, distance arrays and the output word register.
  spd_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_valid     (in_tvalid),
    .in_weight    (in_tdata),
    .in_last      (in_tlast),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_vertex   (vertex),
    .out_distance (distance),
    .out_reach    (out_tuser),
    .out_last     (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Words are taken only while the sequencer sits in its load phase.
  assign in_tready = cmd.accept;
  assign out_tdata = {distance, vertex};
endmodule
